FILE: rtl/core/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// No dependencies; imported by every module but the checker.
package u16u8_pkg;

  localparam int UnitW   = 16;
  localparam int ByteW   = 8;
  localparam int MaxBytes = 4;
  localparam int CountW  = 3;   // holds 0 .. MaxBytes
  localparam int HeldW   = 10;
  localparam int ScalarW = 21;

  localparam logic [UnitW-1:0]   SurLo    = 16'hD800;
  localparam logic [UnitW-1:0]   SurHi    = 16'hDFFF;
  localparam logic [UnitW-1:0]   LowSur   = 16'hDC00;
  localparam logic [UnitW-1:0]   TwoByte  = 16'h0080;
  localparam logic [UnitW-1:0]   ThreeByte = 16'h0800;
  localparam logic [ScalarW-1:0] PlaneOne = 21'h10000;

  localparam logic [ByteW-1:0] Lead4 = 8'hF0;
  localparam logic [ByteW-1:0] Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Cont  = 8'h80;
  localparam logic [ByteW-1:0] LoneSur = 8'h00;

  // One input item as held in the input register
  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             final_unit;
  } unit_t;

  // Encoded bytes of one item, byte 0 first on the wire
  typedef struct packed {
    logic [CountW-1:0]               count;
    logic [MaxBytes-1:0][ByteW-1:0]  bytes;
  } enc_t;

endpackage

FILE: rtl/core/utf16_to_utf8_encoder.sv
// Top level of the UTF-16 to UTF-8 encoder: input register, encoder, serialiser.
// Depends on u16u8_pkg, u16u8_in_stage, u16u8_encode and u16u8_emit.
//
//  channel | dir | tdata              | tlast       | handshake
//  in_     | in  | [15:0] code_unit   | final_unit  | in_tvalid/in_tready
//  out_    | out | [7:0]  out_byte    | run_end     | out_tvalid/out_tready
//
// An item yields 1 to 3 UTF-8 bytes, 4 for the second unit of a pair; a held
// surrogate yields none. The output serialiser sends one byte per cycle while
// out_tready is high. The first byte passes the input register and the result
// register before it is offered. Reset is synchronous and clears the pairing
// state and all valid flags. While the serialiser is busy the input register
// holds one item; unless that item yields no bytes, in_tready stays low until
// the last byte of the previous item leaves.
module utf16_to_utf8_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] code_unit
  input  logic        in_tlast,    // final_unit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast    // run_end
);
  import u16u8_pkg::*;

  unit_t in_item, hold_item;
  enc_t  enc;
  logic  hold_valid, advance, load, free;

  assign in_item.code_unit  = in_tdata;
  assign in_item.final_unit = in_tlast;

  // Move the held item on when the serialiser can take its bytes
  assign advance = hold_valid && (free || (enc.count == '0));
  assign load    = advance && (enc.count != '0);

  u16u8_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  u16u8_encode u_enc (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (hold_item),
    .advance (advance),
    .enc     (enc)
  );

  u16u8_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .enc        (enc),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

FILE: rtl/core/u16u8_in_stage.sv
// Input register of the encoder: takes one code unit item per handshake.
// Depends on u16u8_pkg.
module u16u8_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  u16u8_pkg::unit_t in_item,
  input  logic             advance,
  output logic             hold_valid,
  output u16u8_pkg::unit_t hold_item
);
  import u16u8_pkg::*;

  logic  valid_r, valid_nxt;
  unit_t item_r;

  // Free when empty or when the held item moves on this cycle
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  // Control flag reset, payload loaded on acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

FILE: rtl/core/u16u8_encode.sv
// Byte encoder with surrogate pairing state for the UTF-16 to UTF-8 block.
// Depends on u16u8_pkg.
module u16u8_encode (
  input  logic             clk,
  input  logic             rst_n,
  input  u16u8_pkg::unit_t item,
  input  logic             advance,
  output u16u8_pkg::enc_t  enc
);
  import u16u8_pkg::*;

  logic             pending_r, pending_nxt;
  logic [HeldW-1:0] held_r, held_nxt;
  logic             first_low_r, first_low_nxt;

  logic [UnitW-1:0]   unit;
  logic               is_sur;
  logic [HeldW-1:0]   hi, lo;
  logic [ScalarW-1:0] ch;

  assign unit   = item.code_unit;
  assign is_sur = (unit >= SurLo) && (unit <= SurHi);

  // Order the pair halves by the kind of the held unit
  always_comb begin
    if (first_low_r) begin
      hi = unit[HeldW-1:0];
      lo = held_r;
    end else begin
      hi = held_r;
      lo = unit[HeldW-1:0];
    end
    ch = PlaneOne + {1'b0, hi, lo};
  end

  // Build the byte group and the next pairing state
  always_comb begin
    enc           = '0;
    pending_nxt   = pending_r;
    held_nxt      = held_r;
    first_low_nxt = first_low_r;
    if (pending_r) begin
      enc.count     = CountW'(4);
      enc.bytes[0]  = Lead4 | {5'b0, ch[20:18]};
      enc.bytes[1]  = Cont  | {2'b0, ch[17:12]};
      enc.bytes[2]  = Cont  | {2'b0, ch[11:6]};
      enc.bytes[3]  = Cont  | {2'b0, ch[5:0]};
      pending_nxt   = 1'b0;
      held_nxt      = '0;
      first_low_nxt = 1'b0;
    end else if (is_sur) begin
      if (item.final_unit) begin
        enc.count    = CountW'(1);
        enc.bytes[0] = LoneSur;
      end else begin
        pending_nxt   = 1'b1;
        held_nxt      = unit[HeldW-1:0];
        first_low_nxt = (unit >= LowSur);
      end
    end else if (unit >= ThreeByte) begin
      enc.count    = CountW'(3);
      enc.bytes[0] = Lead3 | {4'b0, unit[15:12]};
      enc.bytes[1] = Cont  | {2'b0, unit[11:6]};
      enc.bytes[2] = Cont  | {2'b0, unit[5:0]};
    end else if (unit >= TwoByte) begin
      enc.count    = CountW'(2);
      enc.bytes[0] = Lead2 | {3'b0, unit[10:6]};
      enc.bytes[1] = Cont  | {2'b0, unit[5:0]};
    end else begin
      enc.count    = CountW'(1);
      enc.bytes[0] = unit[ByteW-1:0];
    end
  end

  // Update pairing state only when the item is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      held_r      <= '0;
      first_low_r <= 1'b0;
    end else if (advance) begin
      pending_r   <= pending_nxt;
      held_r      <= held_nxt;
      first_low_r <= first_low_nxt;
    end
  end

endmodule

FILE: rtl/core/u16u8_emit.sv
// Result register and byte serialiser: sends each group byte by byte.
// Depends on u16u8_pkg.
module u16u8_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  u16u8_pkg::enc_t             enc,
  output logic                        free,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [u16u8_pkg::ByteW-1:0] out_byte,
  output logic                        out_last
);
  import u16u8_pkg::*;

  logic [CountW-1:0]              rem_r, rem_nxt;
  logic [MaxBytes-1:0][ByteW-1:0] data_r, data_nxt;

  assign out_tvalid = (rem_r != '0);
  assign out_last   = (rem_r == CountW'(1));
  assign out_byte   = data_r[0];

  // Ready for a new group when empty or the final byte leaves now
  assign free = (rem_r == '0) || (out_last && out_tready);

  // Load a new group or shift out the byte just taken
  always_comb begin
    rem_nxt  = rem_r;
    data_nxt = data_r;
    if (load) begin
      rem_nxt  = enc.count;
      data_nxt = enc.bytes;
    end else if (out_tvalid && out_tready) begin
      rem_nxt  = rem_r - CountW'(1);
      data_nxt = {{ByteW{1'b0}}, data_r[MaxBytes-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: rtl/core/u16u8_checker.sv
// Port-level checks for the UTF-16 to UTF-8 encoder, bound to the top level.
// Depends only on the top level's ports.
module u16u8_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output item changed");

  // Drop output valid after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Accept input whenever no byte waits at the output
  a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output empty");

  // A byte that is not the end of its group is a lead or continuation byte
  a_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[7])
    else $error("ASCII byte inside a multibyte group");

  // A lead byte never closes a group
  a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] && out_tdata[6] |-> !out_tlast)
    else $error("lead byte marked as last");

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf16_to_utf8_encoder: drives UTF-16 code units,
// predicts the UTF-8 bytes of each accepted unit and checks every output item.
// Depends on u16u8_pkg and the encoder RTL only.
module testbench;
  import u16u8_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int LongStall   = 300;
  localparam int UnitsPerPhase = 107;

  typedef struct {
    logic [15:0] code;
    logic        fin;
  } src_unit_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } utf8_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  src_unit_t   src_units[$];
  utf8_byte_t  utf8_expected[$];

  // Pairing state of the predictor
  logic        sur_held = 1'b0;
  logic [9:0]  sur_bits = '0;
  logic        sur_is_low = 1'b0;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        long_stall_req = 1'b0;
  logic        long_stall_done = 1'b0;
  int          stall_left = 0;
  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          units_queued = 0;

  utf16_to_utf8_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_byte(input logic [7:0] b, input logic last);
    utf8_byte_t e;
    e.data = b;
    e.last = last;
    utf8_expected.insert(utf8_expected.size(), e);
  endfunction

  // Work out the UTF-8 bytes of one accepted code unit and advance pairing state
  function automatic void encode_unit(input logic [15:0] cu, input logic fin);
    logic [20:0] scalar;
    logic [9:0]  hi10;
    logic [9:0]  lo10;
    if (sur_held) begin
      if (sur_is_low) begin
        lo10 = sur_bits;
        hi10 = cu[9:0];
      end else begin
        hi10 = sur_bits;
        lo10 = cu[9:0];
      end
      scalar = PlaneOne + {1'b0, hi10, lo10};
      sur_held = 1'b0;
      sur_bits = '0;
      sur_is_low = 1'b0;
      push_byte(Lead4 | {5'b0, scalar[20:18]}, 1'b0);
      push_byte(Cont | {2'b0, scalar[17:12]}, 1'b0);
      push_byte(Cont | {2'b0, scalar[11:6]}, 1'b0);
      push_byte(Cont | {2'b0, scalar[5:0]}, 1'b1);
    end else if (cu >= SurLo && cu <= SurHi) begin
      if (fin) begin
        push_byte(LoneSur, 1'b1);
      end else begin
        sur_held = 1'b1;
        sur_bits = cu[9:0];
        sur_is_low = (cu >= LowSur);
      end
    end else if (cu >= ThreeByte) begin
      push_byte(Lead3 | {4'b0, cu[15:12]}, 1'b0);
      push_byte(Cont | {2'b0, cu[11:6]}, 1'b0);
      push_byte(Cont | {2'b0, cu[5:0]}, 1'b1);
    end else if (cu >= TwoByte) begin
      push_byte(Lead2 | {3'b0, cu[10:6]}, 1'b0);
      push_byte(Cont | {2'b0, cu[5:0]}, 1'b1);
    end else begin
      push_byte(cu[7:0], 1'b1);
    end
  endfunction

  // Driver: predict on acceptance, then offer the next pending item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid)
        encode_unit(in_tdata, in_tlast);
      if (src_units.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        src_unit_t u;
        u = src_units.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= u.code;
        in_tlast  <= u.fin;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each output item, then pick the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (utf8_expected.size() == 0) begin
          $error("unexpected item: out_byte %h run_end %b", out_tdata, out_tlast);
          mismatches++;
        end else begin
          utf8_byte_t e;
          e = utf8_expected.pop_front();
          if (out_tdata !== e.data) begin
            $error("out_byte: expected %h, actual %h", e.data, out_tdata);
            mismatches++;
          end
          if (out_tlast !== e.last) begin
            $error("run_end: expected %b, actual %b", e.last, out_tlast);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (long_stall_req && !long_stall_done) begin
        stall_left <= LongStall;
        long_stall_done <= 1'b1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_unit(input logic [15:0] cu, input logic fin);
    src_unit_t u;
    u.code = cu;
    u.fin = fin;
    src_units.insert(src_units.size(), u);
    units_queued++;
  endtask

  function automatic logic [15:0] pick_three_byte();
    logic [15:0] v;
    do v = 16'($urandom_range(16'hFFFF, 16'h0800));
    while (v >= SurLo && v <= SurHi);
    return v;
  endfunction

  function automatic logic [15:0] pick_high_sur();
    return 16'($urandom_range(16'hDBFF, 16'hD800));
  endfunction

  function automatic logic [15:0] pick_low_sur();
    return 16'($urandom_range(16'hDFFF, 16'hDC00));
  endfunction

  // One random string of 1 to 8 tokens, mostly well formed; the last unit is final
  task automatic queue_string();
    int len;
    int k;
    int pick;
    logic fin;
    len = $urandom_range(8, 1);
    for (k = 0; k < len; k++) begin
      fin = (k == len - 1);
      pick = $urandom_range(99);
      if (pick < 20) begin
        queue_unit(16'($urandom_range(16'h007F, 0)), fin);
      end else if (pick < 35) begin
        queue_unit(16'($urandom_range(16'h07FF, 16'h0080)), fin);
      end else if (pick < 55) begin
        queue_unit(pick_three_byte(), fin);
      end else if (pick < 73) begin
        queue_unit(pick_high_sur(), 1'b0);
        queue_unit(pick_low_sur(), fin);
      end else if (pick < 80) begin
        // reversed pair
        queue_unit(pick_low_sur(), 1'b0);
        queue_unit(pick_high_sur(), fin);
      end else if (pick < 86) begin
        // lone surrogate closes the string
        queue_unit(($urandom_range(1) != 0) ? pick_high_sur() : pick_low_sur(), 1'b1);
        k = len;
      end else begin
        // raw noise, may pair with whatever follows
        queue_unit(16'($urandom_range(16'hFFFF, 0)), fin);
      end
    end
  endtask

  // Extremes of every width class and each pairing corner
  task automatic queue_directed();
    queue_unit(16'h0000, 1'b1);
    queue_unit(16'h007F, 1'b0);
    queue_unit(16'h0080, 1'b0);
    queue_unit(16'h07FF, 1'b0);
    queue_unit(16'h0800, 1'b0);
    queue_unit(16'hD7FF, 1'b0);
    queue_unit(16'hE000, 1'b0);
    queue_unit(16'hFFFF, 1'b1);
    // smallest and largest scalar, high first
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'hDC00, 1'b0);
    queue_unit(16'hDBFF, 1'b0);
    queue_unit(16'hDFFF, 1'b1);
    // low first
    queue_unit(16'hDC00, 1'b0);
    queue_unit(16'hD800, 1'b0);
    // held surrogate paired with a plain unit, and with a same-kind surrogate
    queue_unit(16'hD801, 1'b0);
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'hDBFF, 1'b0);
    queue_unit(16'hDFFF, 1'b0);
    queue_unit(16'hDC00, 1'b0);
    // lone surrogates as last unit
    queue_unit(16'hD800, 1'b1);
    queue_unit(16'hDFFF, 1'b1);
    // held surrogate whose partner is final and not a surrogate
    queue_unit(16'hDABC, 1'b0);
    queue_unit(16'hFFFF, 1'b1);
  endtask

  // Sequencer: reset, then three traffic phases, each drained before the next
  initial begin
    int phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (phase = 0; phase < 3; phase++) begin
      @(negedge clk);
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 80;
          queue_directed();
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (units_queued < UnitsPerPhase * (phase + 1))
        queue_string();
      // hold off the receiver while the sender keeps offering
      if (phase == 2)
        long_stall_req = 1'b1;
      while (src_units.size() > 0 || in_tvalid || utf8_expected.size() > 0)
        @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (mismatches == 0 && utf8_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
